### sv/rpr_pkg.sv
// Shared constants, types and rounding helper for the rotary position rotate block.
`timescale 1ns / 1ps

package rpr_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int MAX_HALF_DIM  = 64;
    localparam int ELEM_W        = 16;
    localparam int ANGLE_W       = 16;

    localparam int POS_W   = $clog2(MAX_POSITIONS);
    localparam int PAIR_W  = $clog2(MAX_HALF_DIM);
    localparam int ADDR_W  = POS_W + PAIR_W;
    localparam int WORD_W  = 2 * ANGLE_W;
    localparam int PROD_W  = ELEM_W + ANGLE_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = ANGLE_W - 2;
    localparam int SHR_W   = ACC_W - FRAC_W;

    localparam int HALF_DIM_W = 7;
    localparam int KV_COUNT_W = 9;
    localparam int HEAD_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_DIM      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KV_HEAD_COUNT = 2'd1;

    localparam logic KIND_ROTATE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    localparam logic [HALF_DIM_W-1:0] HALF_DIM_RESET = 7'd64;
    localparam logic [KV_COUNT_W-1:0] KV_COUNT_RESET = 9'd256;
    localparam logic [HALF_DIM_W-1:0] HALF_DIM_LIMIT = HALF_DIM_W'(MAX_HALF_DIM);

    typedef struct packed {
        logic key_valid;
        logic index_error;
    } rot_flags_t;

    typedef struct packed {
        logic en2;
        logic en3;
    } stage_en_t;

    // Round half up from Q.14 and saturate to the element range.
    function automatic logic signed [ELEM_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        logic signed [SHR_W-1:0] shr;
        logic signed [SHR_W-1:0] max_v;
        logic signed [SHR_W-1:0] min_v;
        biased = acc + ACC_W'(1 << (FRAC_W - 1));
        shr    = SHR_W'(biased >>> FRAC_W);
        max_v  = SHR_W'((1 << (ELEM_W - 1)) - 1);
        min_v  = -max_v - SHR_W'(1);
        if (shr > max_v)
        begin
            return max_v[ELEM_W-1:0];
        end
        else if (shr < min_v)
        begin
            return min_v[ELEM_W-1:0];
        end
        return shr[ELEM_W-1:0];
    endfunction

endpackage

### sv/rpr_table.sv
// Cosine/sine table: one write port, one registered read port.
`timescale 1ns / 1ps

module rpr_table
    import rpr_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [MAX_POSITIONS * MAX_HALF_DIM];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data while the stage that uses it is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/rpr_rotate.sv
// Rotation datapath: product stage, then sum, round, saturate into the output register.
`timescale 1ns / 1ps

module rpr_rotate
    import rpr_pkg::*;
(
    input  logic                     clk,
    input  stage_en_t                stage_en,
    input  logic [WORD_W-1:0]        angle_word,
    input  logic signed [ELEM_W-1:0] qx,
    input  logic signed [ELEM_W-1:0] qy,
    input  logic signed [ELEM_W-1:0] kx,
    input  logic signed [ELEM_W-1:0] ky,
    input  rot_flags_t               flags_in,
    output logic signed [ELEM_W-1:0] query_first_out,
    output logic signed [ELEM_W-1:0] query_second_out,
    output logic signed [ELEM_W-1:0] key_first_out,
    output logic signed [ELEM_W-1:0] key_second_out,
    output rot_flags_t               flags_out
);

    logic signed [ANGLE_W-1:0] c;
    logic signed [ANGLE_W-1:0] s;

    logic signed [PROD_W-1:0] qxc_reg, qys_reg, qyc_reg, qxs_reg;
    logic signed [PROD_W-1:0] kxc_reg, kys_reg, kyc_reg, kxs_reg;
    rot_flags_t               flags2_reg;

    logic signed [ACC_W-1:0] q1_acc, q2_acc, k1_acc, k2_acc;

    logic signed [ELEM_W-1:0] q1_reg, q2_reg, k1_reg, k2_reg;
    rot_flags_t               flags3_reg;

    assign c = angle_word[WORD_W-1:ANGLE_W];
    assign s = angle_word[ANGLE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en.en2)
        begin
            qxc_reg    <= qx * c;
            qys_reg    <= qy * s;
            qyc_reg    <= qy * c;
            qxs_reg    <= qx * s;
            kxc_reg    <= kx * c;
            kys_reg    <= ky * s;
            kyc_reg    <= ky * c;
            kxs_reg    <= kx * s;
            flags2_reg <= flags_in;
        end
    end

    assign q1_acc = ACC_W'(qxc_reg) - ACC_W'(qys_reg);
    assign q2_acc = ACC_W'(qyc_reg) + ACC_W'(qxs_reg);
    assign k1_acc = ACC_W'(kxc_reg) - ACC_W'(kys_reg);
    assign k2_acc = ACC_W'(kyc_reg) + ACC_W'(kxs_reg);

    // drop results to zero for a bad pair index or an unrotated key
    always_ff @(posedge clk)
    begin
        if (stage_en.en3)
        begin
            q1_reg     <= flags2_reg.index_error ? '0 : round_sat(q1_acc);
            q2_reg     <= flags2_reg.index_error ? '0 : round_sat(q2_acc);
            k1_reg     <= flags2_reg.key_valid ? round_sat(k1_acc) : '0;
            k2_reg     <= flags2_reg.key_valid ? round_sat(k2_acc) : '0;
            flags3_reg <= flags2_reg;
        end
    end

    assign query_first_out  = q1_reg;
    assign query_second_out = q2_reg;
    assign key_first_out    = k1_reg;
    assign key_second_out   = k2_reg;
    assign flags_out        = flags3_reg;

endmodule

### sv/rotary_position_rotate.sv
// Top level: rotary position embedding (split-half form) with a loadable angle table.
//
//  Channel  Signals                                   Direction  Beat carries
//  ------   ----------------------------------------  ---------  -------------------------
//  in       in_valid / in_ready + item fields         sink       one load or rotate item
//  out      out_valid / out_ready + result fields     source     one rotated query/key set
//  cfg      cfg_valid / cfg_ready, cfg_index/cfg_data sink       one register write
//
//  Throughput is one item per cycle while the output is not stalled. A rotate beat has
//  its table read and stage 1 capture at the accepting edge, then its products, then
//  round/saturate into the output register; a stall can hold it in any stage. Load beats
//  write the table in the cycle they are accepted and produce no result.
//  The table has one write and one read port; a load and a later rotate to the same
//  entry never touch it in the same cycle, so no forwarding is needed.
//  Reset clears the pipeline valids and sets the configuration registers to their reset
//  values; the table needs no clearing pass.
//  A stall at the output only backs up the stages that are full; bubbles still fill.
`timescale 1ns / 1ps

module rotary_position_rotate
    import rpr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [POS_W-1:0]             position,
    input  logic [PAIR_W-1:0]            pair_index,
    input  logic [HEAD_W-1:0]            head_index,
    input  logic signed [ELEM_W-1:0]     query_first,
    input  logic signed [ELEM_W-1:0]     query_second,
    input  logic signed [ELEM_W-1:0]     key_first,
    input  logic signed [ELEM_W-1:0]     key_second,
    input  logic signed [ANGLE_W-1:0]    cos_value,
    input  logic signed [ANGLE_W-1:0]    sin_value,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ELEM_W-1:0]     query_first_out,
    output logic signed [ELEM_W-1:0]     query_second_out,
    output logic signed [ELEM_W-1:0]     key_first_out,
    output logic signed [ELEM_W-1:0]     key_second_out,
    output logic                         key_valid,
    output logic                         index_error,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    // configuration registers
    logic [HALF_DIM_W-1:0] half_dim_reg;
    logic [KV_COUNT_W-1:0] kv_head_count_reg;

    // pipeline valids: stage 1 = table read, 2 = products, 3 = output register
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;

    logic      en1;
    stage_en_t stage_en;
    logic      accept;
    logic      load_wr;

    // stage 1 payload
    logic signed [ELEM_W-1:0] qx1_reg, qy1_reg, kx1_reg, ky1_reg;
    rot_flags_t               flags1_reg;

    logic [HALF_DIM_W-1:0] pair_limit;
    rot_flags_t            flags_in;
    logic [ADDR_W-1:0]     item_addr;
    logic [WORD_W-1:0]     angle_word;
    rot_flags_t            flags_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_dim_reg      <= HALF_DIM_RESET;
            kv_head_count_reg <= KV_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HALF_DIM:      half_dim_reg      <= cfg_data[HALF_DIM_W-1:0];
                REG_KV_HEAD_COUNT: kv_head_count_reg <= cfg_data[KV_COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Advance a stage when its successor is empty or moving on.
    assign stage_en.en3 = !v3_reg || out_ready;
    assign stage_en.en2 = !v2_reg || stage_en.en3;
    assign en1          = !v1_reg || stage_en.en2;
    assign in_ready     = en1;

    assign accept  = in_valid && in_ready;
    assign load_wr = accept && (kind == KIND_LOAD);

    // Pair limit is half_dim capped at the table width.
    assign pair_limit = (half_dim_reg > HALF_DIM_LIMIT) ? HALF_DIM_LIMIT : half_dim_reg;

    always_comb
    begin
        flags_in.index_error = ({1'b0, pair_index} >= pair_limit);
        flags_in.key_valid   = !flags_in.index_error
                               && ({1'b0, head_index} < kv_head_count_reg);
    end

    // Row of the table is the position, column the pair index.
    assign item_addr = {position, pair_index};

    assign v1_next = en1 ? (accept && (kind == KIND_ROTATE)) : v1_reg;
    assign v2_next = stage_en.en2 ? v1_reg : v2_reg;
    assign v3_next = stage_en.en3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            qx1_reg    <= query_first;
            qy1_reg    <= query_second;
            kx1_reg    <= key_first;
            ky1_reg    <= key_second;
            flags1_reg <= flags_in;
        end
    end

    rpr_table u_table (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (item_addr),
        .wr_data ({cos_value, sin_value}),
        .rd_en   (en1),
        .rd_addr (item_addr),
        .rd_data (angle_word)
    );

    rpr_rotate u_rotate (
        .clk              (clk),
        .stage_en         (stage_en),
        .angle_word       (angle_word),
        .qx               (qx1_reg),
        .qy               (qy1_reg),
        .kx               (kx1_reg),
        .ky               (ky1_reg),
        .flags_in         (flags1_reg),
        .query_first_out  (query_first_out),
        .query_second_out (query_second_out),
        .key_first_out    (key_first_out),
        .key_second_out   (key_second_out),
        .flags_out        (flags_out)
    );

    assign out_valid   = v3_reg;
    assign key_valid   = flags_out.key_valid;
    assign index_error = flags_out.index_error;

`ifndef SYNTH
    // A bad pair index clears every other result field.
    a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> !key_valid && query_first_out == 0
                                     && query_second_out == 0 && key_first_out == 0
                                     && key_second_out == 0)
        else $error("index_error result carries nonzero fields");

    // An unrotated key reads as zero.
    a_key_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_valid |-> key_first_out == 0 && key_second_out == 0)
        else $error("key outputs nonzero without key_valid");

    // A stalled table-read stage keeps its item and its read data.
    a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !stage_en.en2 |=> v1_reg && $stable(angle_word))
        else $error("table read data lost while stage 1 stalled");

    // Items are not taken while the first stage is full and blocked.
    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !stage_en.en2 |-> !in_ready)
        else $error("input accepted into a blocked stage");
`endif

endmodule

### dv/rpr_checker.sv
// Scoreboard for rotary_position_rotate: mirrors the angle table and registers, checks each result beat.
`timescale 1ns / 1ps

module rpr_checker
    import rpr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      kind,
    input  logic [POS_W-1:0]          position,
    input  logic [PAIR_W-1:0]         pair_index,
    input  logic [HEAD_W-1:0]         head_index,
    input  logic signed [ELEM_W-1:0]  query_first,
    input  logic signed [ELEM_W-1:0]  query_second,
    input  logic signed [ELEM_W-1:0]  key_first,
    input  logic signed [ELEM_W-1:0]  key_second,
    input  logic signed [ANGLE_W-1:0] cos_value,
    input  logic signed [ANGLE_W-1:0] sin_value,

    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [ELEM_W-1:0]  query_first_out,
    input  logic signed [ELEM_W-1:0]  query_second_out,
    input  logic signed [ELEM_W-1:0]  key_first_out,
    input  logic signed [ELEM_W-1:0]  key_second_out,
    input  logic                      key_valid,
    input  logic                      index_error,

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    output int                        mismatches,
    output int                        pending
);

    typedef struct packed {
        logic signed [ELEM_W-1:0] q_first;
        logic signed [ELEM_W-1:0] q_second;
        logic signed [ELEM_W-1:0] k_first;
        logic signed [ELEM_W-1:0] k_second;
        rot_flags_t               flags;
    } rotated_beat_t;

    logic [WORD_W-1:0]     angle_words [0:(1<<ADDR_W)-1];
    logic [HALF_DIM_W-1:0] half_dim_q = HALF_DIM_RESET;
    logic [KV_COUNT_W-1:0] kv_count_q = KV_COUNT_RESET;
    rotated_beat_t         rotated_q [$];

    // Round half up out of Q.14, then clamp to the element range.
    function automatic logic signed [ELEM_W-1:0] round_q14(input longint acc);
        longint sat_hi;
        longint r;
        sat_hi = (longint'(1) <<< (ELEM_W - 1)) - 1;
        r = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (r > sat_hi)
        begin
            r = sat_hi;
        end
        else if (r < -sat_hi - 1)
        begin
            r = -sat_hi - 1;
        end
        return ELEM_W'(r);
    endfunction

    function automatic rotated_beat_t rotate_pairs(
        input logic [WORD_W-1:0]        word,
        input logic [PAIR_W-1:0]        pair,
        input logic [HEAD_W-1:0]        head,
        input logic signed [ELEM_W-1:0] qf,
        input logic signed [ELEM_W-1:0] qs,
        input logic signed [ELEM_W-1:0] kf,
        input logic signed [ELEM_W-1:0] ks
    );
        rotated_beat_t         res;
        longint                c;
        longint                s;
        logic [HALF_DIM_W-1:0] lim;
        res = '0;
        lim = (half_dim_q > HALF_DIM_LIMIT) ? HALF_DIM_LIMIT : half_dim_q;
        // out-of-range pair: error flag only, everything else zero
        if (pair >= lim)
        begin
            res.flags.index_error = 1'b1;
            return res;
        end
        c = longint'($signed(word[WORD_W-1:ANGLE_W]));
        s = longint'($signed(word[ANGLE_W-1:0]));
        res.q_first  = round_q14(longint'(qf) * c - longint'(qs) * s);
        res.q_second = round_q14(longint'(qs) * c + longint'(qf) * s);
        if (head < kv_count_q)
        begin
            res.k_first         = round_q14(longint'(kf) * c - longint'(ks) * s);
            res.k_second        = round_q14(longint'(ks) * c + longint'(kf) * s);
            res.flags.key_valid = 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic signed [ELEM_W-1:0] want,
                               input logic signed [ELEM_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t rpr_checker: %s expected %0d, got %0d", $time, field, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rotated_beat_t want;
        if (!rst_n)
        begin
            half_dim_q = HALF_DIM_RESET;
            kv_count_q = KV_COUNT_RESET;
            rotated_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HALF_DIM)
                begin
                    half_dim_q = cfg_data[HALF_DIM_W-1:0];
                end
                else if (cfg_index == REG_KV_HEAD_COUNT)
                begin
                    kv_count_q = cfg_data[KV_COUNT_W-1:0];
                end
            end

            if (out_valid && out_ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t rpr_checker: unexpected beat q=%0d,%0d k=%0d,%0d kv=%b err=%b",
                                 $time, query_first_out, query_second_out, key_first_out,
                                 key_second_out, key_valid, index_error);
                    end
                end
                else
                begin
                    want = rotated_q.pop_front();
                    check_field("query_first_out", want.q_first, query_first_out);
                    check_field("query_second_out", want.q_second, query_second_out);
                    check_field("key_first_out", want.k_first, key_first_out);
                    check_field("key_second_out", want.k_second, key_second_out);
                    check_field("key_valid", want.flags.key_valid, key_valid);
                    check_field("index_error", want.flags.index_error, index_error);
                end
            end

            if (in_valid && in_ready)
            begin
                if (kind == KIND_LOAD)
                begin
                    angle_words[{position, pair_index}] = {cos_value, sin_value};
                end
                else
                begin
                    rotated_q.push_back(rotate_pairs(angle_words[{position, pair_index}],
                                                     pair_index, head_index, query_first,
                                                     query_second, key_first, key_second));
                end
            end

            pending = rotated_q.size();
        end
    end

endmodule

### dv/tb.sv
// Testbench top for rotary_position_rotate: stimulus, result-side backpressure and verdict.
`timescale 1ns / 1ps

module tb;
    import rpr_pkg::*;

    // Stimulus budget and timing knobs.
    localparam int ITEM_TOTAL   = 1350;
    localparam int QUIET_TAIL   = 200;   // last items go out with no idling on either side
    localparam int DRAIN_CYCLES = 12;    // extra wait in settle after the last expected result is back
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on any channel

    // Register indexes past the end of the register list; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;

    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic                      kind         = KIND_ROTATE;
    logic [POS_W-1:0]          position     = '0;
    logic [PAIR_W-1:0]         pair_index   = '0;
    logic [HEAD_W-1:0]         head_index   = '0;
    logic signed [ELEM_W-1:0]  query_first  = '0;
    logic signed [ELEM_W-1:0]  query_second = '0;
    logic signed [ELEM_W-1:0]  key_first    = '0;
    logic signed [ELEM_W-1:0]  key_second   = '0;
    logic signed [ANGLE_W-1:0] cos_value    = '0;
    logic signed [ANGLE_W-1:0] sin_value    = '0;

    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic signed [ELEM_W-1:0]  query_first_out;
    logic signed [ELEM_W-1:0]  query_second_out;
    logic signed [ELEM_W-1:0]  key_first_out;
    logic signed [ELEM_W-1:0]  key_second_out;
    logic                      key_valid;
    logic                      index_error;

    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index    = REG_HALF_DIM;
    logic [CFG_DATA_W-1:0]     cfg_data     = '0;

    int                        mismatches;
    int                        pending;

    // Stimulus-side bookkeeping: which table entries hold data, and the current settings,
    // so that rotates only ever read written entries and can be steered at the pair limit.
    bit                        table_loaded [0:(1<<ADDR_W)-1];
    logic [ADDR_W-1:0]         loaded_addrs [$];
    logic [POS_W-1:0]          pos_pool [16];
    logic [HALF_DIM_W-1:0]     cur_half = HALF_DIM_RESET;
    logic [KV_COUNT_W-1:0]     cur_kv   = KV_COUNT_RESET;
    bit                        idle_on  = 1'b0;
    int                        sent_items;
    int                        ready_left;
    int                        quiet_cycles;

    rotary_position_rotate u_dut (.*);

    rpr_checker u_check (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Element values: mostly uniform, with the extremes, -1 and zero mixed in.
    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(ELEM_W-1){1'b1}}};
            1:       return {1'b1, {(ELEM_W-1){1'b0}}};
            2:       return '1;
            3:       return '0;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Table values: Q1.14 in [-1.0, 1.0], now and then a raw 16-bit pattern.
    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        int v;
        case ($urandom_range(0, 19))
            0:       v = 1 << FRAC_W;
            1:       v = -(1 << FRAC_W);
            2:       v = int'($urandom);
            3:       v = 0;
            default: v = int'($urandom_range(0, 2 << FRAC_W)) - (1 << FRAC_W);
        endcase
        return ANGLE_W'(v);
    endfunction

    // Present one beat on the item channel and hold it until accepted. Now and then
    // drop valid first for an idle burst.
    task automatic send_item(
        input logic                      k,
        input logic [POS_W-1:0]          pos,
        input logic [PAIR_W-1:0]         pair,
        input logic [HEAD_W-1:0]         head,
        input logic signed [ELEM_W-1:0]  qf,
        input logic signed [ELEM_W-1:0]  qs,
        input logic signed [ELEM_W-1:0]  kf,
        input logic signed [ELEM_W-1:0]  ks,
        input logic signed [ANGLE_W-1:0] cv,
        input logic signed [ANGLE_W-1:0] sv
    );
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        kind         <= k;
        position     <= pos;
        pair_index   <= pair;
        head_index   <= head;
        query_first  <= qf;
        query_second <= qs;
        key_first    <= kf;
        key_second   <= ks;
        cos_value    <= cv;
        sin_value    <= sv;
        do
            @(posedge clk);
        while (!in_ready);
        sent_items++;
    endtask

    // Write one table word; the element and head fields ride along as noise.
    task automatic load_entry(
        input logic [POS_W-1:0]          pos,
        input logic [PAIR_W-1:0]         pair,
        input logic signed [ANGLE_W-1:0] cv,
        input logic signed [ANGLE_W-1:0] sv
    );
        if (!table_loaded[{pos, pair}])
        begin
            table_loaded[{pos, pair}] = 1'b1;
            loaded_addrs.push_back({pos, pair});
        end
        send_item(KIND_LOAD, pos, pair, HEAD_W'($urandom), rand_elem(), rand_elem(),
                  rand_elem(), rand_elem(), cv, sv);
    endtask

    // Rotate against a written entry; the table-data fields ride along as noise.
    task automatic rotate_entry(
        input logic [POS_W-1:0]         pos,
        input logic [PAIR_W-1:0]        pair,
        input logic [HEAD_W-1:0]        head,
        input logic signed [ELEM_W-1:0] qf,
        input logic signed [ELEM_W-1:0] qs,
        input logic signed [ELEM_W-1:0] kf,
        input logic signed [ELEM_W-1:0] ks
    );
        send_item(KIND_ROTATE, pos, pair, head, qf, qs, kf, ks, rand_angle(), rand_angle());
    endtask

    // Drop valid, hold off until every expected result has come back, then let the
    // pipeline run empty. Sampling at the falling edge keeps clear of the checker update.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write beat; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_HALF_DIM)
        begin
            cur_half = data[HALF_DIM_W-1:0];
        end
        else if (idx == REG_KV_HEAD_COUNT)
        begin
            cur_kv = data[KV_COUNT_W-1:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: ready runs and stalls in random bursts while idling is on;
    // otherwise hold ready high.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_left = $urandom_range(0, 15);
            out_ready <= !idle_on || ($urandom_range(0, 2) != 0);
        end
        else
        begin
            ready_left--;
        end
    end

    // Watchdog: end the run once no channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int                    phase;
        int                    phase_len;
        int                    j;
        int                    t;
        int                    hv;
        int                    roll;
        bit                    use_now;
        logic [ADDR_W-1:0]     addr;
        logic [POS_W-1:0]      pos;
        logic [PAIR_W-1:0]     pair;
        logic [HALF_DIM_W-1:0] eff_half;
        logic [CFG_DATA_W-1:0] hd;
        logic [CFG_DATA_W-1:0] kvd;

        // Hot rows for the random part: both ends of the position range plus a few others,
        // so that rotates keep landing on entries that were just rewritten.
        pos_pool[0] = '0;
        pos_pool[1] = '1;
        for (int i = 2; i < 16; i++)
        begin
            pos_pool[i] = POS_W'($urandom);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------------------------------------------------------------------
        // Directed part, reset settings first (64 pairs, key heads below 256).
        // Each load is followed straight away by a rotate of the same entry, which
        // exercises a table read right behind its write.
        // ---------------------------------------------------------------------------
        // cos = 1.0, sin = 0: identity on the element extremes
        load_entry(0, 0, 16384, 0);
        rotate_entry(0, 0, 0, 32767, -32768, -32768, 32767);
        // last row, last pair, highest head with its key still rotated
        load_entry(1023, 63, -16384, 16384);
        rotate_entry(1023, 63, 255, 32767, -32768, 1, -1);
        // cos = sin = 1.0: saturate high on the query, low on the key
        load_entry(5, 1, 16384, 16384);
        rotate_entry(5, 1, 7, 32767, -32768, -32768, -32768);
        // smallest cos: exact halves round up, toward positive
        load_entry(2, 2, 1, 0);
        rotate_entry(2, 2, 0, 8192, 8191, -8192, -8193);

        // No key heads and a single pair: pair 0 rotates without its key, the rest error out.
        settle();
        write_reg(REG_KV_HEAD_COUNT, 0);
        write_reg(REG_HALF_DIM, 1);
        rotate_entry(0, 0, 0, 12345, -23456, 3456, -4567);
        rotate_entry(5, 1, 255, 32767, 32767, 32767, 32767);
        rotate_entry(1023, 63, 0, -1, -1, -1, -1);

        // Half dimension zero: every rotate raises the index error.
        settle();
        write_reg(REG_HALF_DIM, 0);
        rotate_entry(0, 0, 0, 1000, 2000, 3000, 4000);

        // Writes past the register list must leave both registers alone.
        settle();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        rotate_entry(0, 0, 0, -1000, -2000, -3000, -4000);

        // Data bits above the register width are dropped: 64 pairs, 511 key heads.
        settle();
        write_reg(REG_HALF_DIM, 9'h1C0);
        write_reg(REG_KV_HEAD_COUNT, '1);
        rotate_entry(1023, 63, 255, 20000, -20000, 30000, -30000);

        // Half dimension above the table width is clamped to the table width.
        settle();
        write_reg(REG_HALF_DIM, 127);
        write_reg(REG_KV_HEAD_COUNT, 256);
        rotate_entry(1023, 63, 255, -32768, -32768, 32767, 32767);
        rotate_entry(2, 2, 128, 24576, -24576, 8193, -8193);

        // ---------------------------------------------------------------------------
        // Random part: phases of fresh settings, each a mix of loads, loads followed by
        // an immediate rotate of that entry, and rotates of entries written earlier.
        // ---------------------------------------------------------------------------
        phase = 0;
        while (sent_items < ITEM_TOTAL)
        begin
            settle();
            case ($urandom_range(0, 7))
                0:       hd = 0;
                1:       hd = 1;
                2:       hd = 2;
                3:       hd = 64;
                4:       hd = 127;
                5:       hd = CFG_DATA_W'($urandom);
                default: hd = CFG_DATA_W'($urandom_range(3, 63));
            endcase
            case ($urandom_range(0, 7))
                0:       kvd = 0;
                1:       kvd = 1;
                2:       kvd = 256;
                3:       kvd = '1;
                4:       kvd = 255;
                5:       kvd = CFG_DATA_W'($urandom);
                default: kvd = CFG_DATA_W'($urandom_range(2, 255));
            endcase
            write_reg(REG_HALF_DIM, hd);
            write_reg(REG_KV_HEAD_COUNT, kvd);
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_DATA_W'($urandom));
            end

            // every fourth phase runs with no idling at all
            idle_on   = (phase % 4 != 3);
            phase_len = $urandom_range(60, 140);
            eff_half  = (cur_half > HALF_DIM_LIMIT) ? HALF_DIM_LIMIT : cur_half;

            for (j = 0; j < phase_len && sent_items < ITEM_TOTAL; j++)
            begin
                if (sent_items >= ITEM_TOTAL - QUIET_TAIL)
                begin
                    idle_on = 1'b0;
                end

                // once in the run, hold the sender until the result side has caught up
                if (phase == 2 && j == phase_len / 2)
                begin
                    settle();
                end

                roll = $urandom_range(0, 99);
                if (roll < 25 || loaded_addrs.size() == 0)
                begin
                    // load a hot row, biased to pairs inside the current limit
                    pos = pos_pool[$urandom_range(0, 15)];
                    if (eff_half != 0 && $urandom_range(0, 1))
                    begin
                        pair = PAIR_W'($urandom_range(0, eff_half - 1));
                    end
                    else
                    begin
                        pair = PAIR_W'($urandom_range(0, MAX_HALF_DIM - 1));
                    end
                    load_entry(pos, pair, rand_angle(), rand_angle());
                    addr    = {pos, pair};
                    use_now = 1'($urandom_range(0, 1));
                end
                else if (roll < 30)
                begin
                    // stray load anywhere in the table
                    load_entry(POS_W'($urandom), PAIR_W'($urandom), rand_angle(), rand_angle());
                    use_now = 1'b0;
                end
                else
                begin
                    // rotate a written entry; most draws are steered inside the pair limit
                    addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
                    for (t = 0; t < 8 && roll < 85 && addr[PAIR_W-1:0] >= eff_half; t++)
                    begin
                        addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
                    end
                    use_now = 1'b1;
                end

                if (use_now)
                begin
                    // heads cluster around the key head count to hit both sides of it
                    if ($urandom_range(0, 9) < 3)
                    begin
                        hv = int'(cur_kv) + int'($urandom_range(0, 2)) - 1;
                        hv = (hv < 0) ? 0 : ((hv > 255) ? 255 : hv);
                    end
                    else
                    begin
                        hv = $urandom_range(0, 255);
                    end
                    rotate_entry(addr[ADDR_W-1:PAIR_W], addr[PAIR_W-1:0], HEAD_W'(hv),
                                 rand_elem(), rand_elem(), rand_elem(), rand_elem());
                end
            end
            phase++;
        end

        settle();
        if (mismatches == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

### rotary_position_rotate.f
sv/rpr_pkg.sv
sv/rpr_table.sv
sv/rpr_rotate.sv
sv/rotary_position_rotate.sv
dv/rpr_checker.sv
dv/tb.sv
